// ===== rtl/core/ngtp_pkg.sv =====
// shared types, codes and helpers for the n-gram table predictor
package ngtp_pkg;

  localparam int unsigned DefaultTableDepth = 4096;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned CharW  = 8;
  localparam int unsigned CtxW   = 24;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned CfgW   = 13;

  // request modes
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_PREDICT = 2'd2;

  // configuration register indexes
  localparam logic CFG_ENTRIES = 1'b0;
  localparam logic CFG_ORDER   = 1'b1;

  localparam logic [CharW-1:0] SPACE_CHAR = 8'h20;
  localparam logic [2:0]       MIN_ORDER  = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_CHECK,
    ST_FINISH
  } state_t;

  function automatic logic [CharW-1:0] space_if_zero(input logic [CharW-1:0] b);
    space_if_zero = (b == '0) ? SPACE_CHAR : b;
  endfunction

endpackage

// ===== rtl/core/ngram_table_predict.sv =====
// sorted n-gram table with exact lookup and next-character predict
//
//   channel   dir   handshake               payload
//   request   in    req_valid / req_stall   mode, entry_index, gram_key, gram_count,
//                                           context_bytes
//   result    out   rsp_valid / rsp_stall   hit, found_count, next_char
//   config    in    cfg_we                  cfg_index, cfg_data
//
// write, unused mode, empty lookup and disabled predict: go from accept straight to the
//   result register; a new request is taken only after the last one reaches it
// search: each probe is a table read, then a key compare; up to
//   ceil(log2(n+1)) probes, then for a predict run a table read and a compare per
//   entry scanned, then the result register is loaded
// the table has a single read port and there is one key comparator
// rst is synchronous; req_stall is high during reset and whenever a request is in work
// a stalled result holds in its register; the next request is taken meanwhile
module ngram_table_predict import ngtp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefaultTableDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [1:0]        mode,
  input  logic [IdxW-1:0]   entry_index,
  input  logic [KeyW-1:0]   gram_key,
  input  logic [CountW-1:0] gram_count,
  input  logic [CtxW-1:0]   context_bytes,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic              hit,
  output logic [CountW-1:0] found_count,
  output logic [CharW-1:0]  next_char,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CfgW-1:0]   cfg_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic [CfgW-1:0]   entries_in_use;
  logic [2:0]        model_order;

  logic [1:0]        mode_r;
  logic [KeyW-1:0]   key_r;
  logic [CW-1:0]     lo, hip1, mid_r, first_r, scan_idx;
  logic              found_r;
  logic              hit_r;
  logic [CountW-1:0] cnt_r;
  logic [CharW-1:0]  char_r;

  logic [KeyW+CountW-1:0] mem [TABLE_DEPTH];
  logic [KeyW+CountW-1:0] rd_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic [31:0]       n_wide;
  logic [CW-1:0]     n;
  logic [CW-1:0]     diff, mid;
  logic [KeyW-1:0]   rd_key, cmp_val;
  logic [CountW-1:0] rd_cnt;
  logic              cmp_lt, cmp_eq;
  logic [CW-1:0]     lo_upd, hip1_upd;
  logic              more;
  logic              found_now;
  logic [CW-1:0]     first_now;
  logic [CW-1:0]     scan_nxt;
  logic              scan_more;
  logic              wr_ok;
  logic [KeyW-1:0]   target;

  assign accept   = req_valid && !req_stall;
  assign req_stall = rst || (state != ST_IDLE);
  assign out_free = !rsp_valid || !rsp_stall;

  // datapath around the shared key comparator
  always_comb begin
    n_wide = ({19'b0, entries_in_use} > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                          : {19'b0, entries_in_use};
    n      = n_wide[CW-1:0];
    diff   = hip1 - lo - CW'(1);
    mid    = lo + (diff >> 1);
    rd_key = rd_data[KeyW+CountW-1:CountW];
    rd_cnt = rd_data[CountW-1:0];
    // predict compares the upper three key bytes against the target
    cmp_val = (mode_r == MODE_LOOKUP) ? rd_key : {8'h00, rd_key[KeyW-1:CharW]};
    cmp_lt  = cmp_val < key_r;
    cmp_eq  = cmp_val == key_r;
    lo_upd   = cmp_lt ? (mid_r + CW'(1)) : lo;
    hip1_upd = cmp_lt ? hip1 : mid_r;
    more     = lo_upd < hip1_upd;
    found_now = found_r || cmp_eq;
    first_now = cmp_eq ? mid_r : first_r;
    scan_nxt  = scan_idx + CW'(1);
    scan_more = scan_nxt < n;
    wr_ok     = 32'(entry_index) < 32'(TABLE_DEPTH);
    target    = {8'h00, space_if_zero(context_bytes[23:16]),
                 space_if_zero(context_bytes[15:8]), space_if_zero(context_bytes[7:0])};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_LOOKUP:  state_next = (n == '0) ? ST_FINISH : ST_PROBE;
            MODE_PREDICT: state_next = (model_order >= MIN_ORDER && n != '0) ? ST_PROBE
                                                                              : ST_FINISH;
            default:      state_next = ST_FINISH;
          endcase
        end
      end
      ST_PROBE: state_next = ST_CHECK;
      ST_CHECK: begin
        if (mode_r == MODE_LOOKUP) begin
          state_next = (cmp_eq || !more) ? ST_FINISH : ST_PROBE;
        end else if (more) begin
          state_next = ST_PROBE;
        end else begin
          state_next = found_now ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: state_next = ST_SCAN_CHECK;
      ST_SCAN_CHECK: state_next = (cmp_eq && scan_more) ? ST_SCAN : ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = mid[AW-1:0];
    load_out = 1'b0;
    unique case (state)
      ST_PROBE:  rd_en = 1'b1;
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_idx[AW-1:0];
      end
      ST_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
      model_order    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRIES: entries_in_use <= cfg_data;
        CFG_ORDER:   model_order    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // entry table
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_WRITE && wr_ok) begin
      mem[AW'(entry_index)] <= {gram_key, gram_count};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // search and scan registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mode_r  <= mode;
          key_r   <= (mode == MODE_LOOKUP) ? gram_key : target;
          lo      <= '0;
          hip1    <= n;
          found_r <= 1'b0;
          hit_r   <= 1'b0;
          cnt_r   <= '0;
          char_r  <= '0;
        end
      end
      ST_PROBE: mid_r <= mid;
      ST_CHECK: begin
        lo   <= lo_upd;
        hip1 <= hip1_upd;
        if (mode_r == MODE_LOOKUP) begin
          if (cmp_eq) begin
            hit_r <= 1'b1;
            cnt_r <= rd_cnt;
          end
        end else begin
          found_r  <= found_now;
          first_r  <= first_now;
          scan_idx <= first_now;
          hit_r    <= found_now;
        end
      end
      ST_SCAN_CHECK: begin
        if (cmp_eq && rd_cnt > cnt_r) begin
          cnt_r  <= rd_cnt;
          char_r <= rd_key[CharW-1:0];
        end
        scan_idx <= scan_nxt;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit         <= hit_r;
      found_count <= cnt_r;
      next_char   <= char_r;
    end
  end

endmodule

// ===== rtl/core/ngtp_checker.sv =====
// port-level checks for the n-gram table predictor, bound to the top level
module ngtp_checker import ngtp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input logic              hit,
  input logic [CountW-1:0] found_count,
  input logic [CharW-1:0]  next_char
);

  // a result waiting on a stall stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  // a miss carries no count and no character
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hit |-> found_count == '0 && next_char == '0)
    else $error("miss with nonzero payload");

  // a predicted character only comes with a hit and a nonzero count
  a_char_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && next_char != '0 |-> hit && found_count != '0)
    else $error("character without hit");

  // one request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

endmodule

bind ngram_table_predict ngtp_checker u_ngtp_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .hit         (hit),
  .found_count (found_count),
  .next_char   (next_char)
);

// ===== tb/ngram_table_predict_tb.sv =====
// self-checking testbench for the n-gram table lookup and next-character predictor
`timescale 1ns / 100ps

module ngram_table_predict_tb import ngtp_pkg::*; ();

  localparam int TABLE_DEPTH  = DefaultTableDepth;
  localparam int QUIET_LIMIT  = 10000;
  localparam int TAIL_CYCLES  = 64;
  localparam int RAND_PHASES  = 16;
  localparam int PHASE_QUERIES = 28;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef enum logic [1:0] {
    STEP_REQ,
    STEP_CFG,
    STEP_PHASE
  } step_kind_t;

  typedef struct packed {
    step_kind_t        kind;
    logic [1:0]        mode;
    logic [IdxW-1:0]   index;
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
    logic [CtxW-1:0]   ctx;
    logic              cfg_idx;
    logic [CfgW-1:0]   cfg_val;
    logic [6:0]        idle_pct;
    logic [6:0]        stall_pct;
  } plan_step_t;

  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] count;
    logic [CharW-1:0]  ch;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [1:0]        mode = '0;
  logic [IdxW-1:0]   entry_index = '0;
  logic [KeyW-1:0]   gram_key = '0;
  logic [CountW-1:0] gram_count = '0;
  logic [CtxW-1:0]   context_bytes = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic              hit;
  logic [CountW-1:0] found_count;
  logic [CharW-1:0]  next_char;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CfgW-1:0]   cfg_data = '0;

  ngram_table_predict dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .mode          (mode),
    .entry_index   (entry_index),
    .gram_key      (gram_key),
    .gram_count    (gram_count),
    .context_bytes (context_bytes),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .hit           (hit),
    .found_count   (found_count),
    .next_char     (next_char),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  plan_step_t request_plan[$];
  answer_t    pending_answers[$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         rsp_stall_pct = 0;
  int         quiet_cycles = 0;

  // shadow copy of the table and registers, updated in request order
  logic [KeyW-1:0]   shadow_key [TABLE_DEPTH];
  logic [CountW-1:0] shadow_cnt [TABLE_DEPTH];
  logic [CfgW-1:0]   shadow_entries = '0;
  logic [2:0]        shadow_order = '0;

  // what the stimulus has put into the table so far, for picking hits
  logic [KeyW-1:0]   plan_key [TABLE_DEPTH];

  function automatic logic [CharW-1:0] blank_as_space(input logic [CharW-1:0] b);
    return (b == '0) ? SPACE_CHAR : b;
  endfunction

  function automatic answer_t table_answer(input logic [1:0] md, input logic [IdxW-1:0] idx,
                                           input logic [KeyW-1:0] key,
                                           input logic [CountW-1:0] cnt,
                                           input logic [CtxW-1:0] ctx);
    answer_t         a;
    int              n, lo, hi, mid, first;
    logic [CtxW-1:0] target;
    a = '0;
    n = (shadow_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_entries);
    lo = 0;
    hi = n - 1;
    first = -1;
    case (md)
      MODE_WRITE: begin
        if (idx < TABLE_DEPTH) begin
          shadow_key[idx] = key;
          shadow_cnt[idx] = cnt;
        end
      end
      MODE_LOOKUP: begin
        while (lo <= hi && !a.hit) begin
          mid = lo + (hi - lo) / 2;
          if (shadow_key[mid] == key) begin
            a.hit = 1'b1;
            a.count = shadow_cnt[mid];
          end else if (shadow_key[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
      MODE_PREDICT: begin
        if (shadow_order >= MIN_ORDER && n > 0) begin
          target = {blank_as_space(ctx[23:16]), blank_as_space(ctx[15:8]),
                    blank_as_space(ctx[7:0])};
          // lower-bound search for the first key of the context run
          while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_key[mid][31:8] < target) begin
              lo = mid + 1;
            end else begin
              if (shadow_key[mid][31:8] == target) first = mid;
              hi = mid - 1;
            end
          end
          if (first >= 0) begin
            a.hit = 1'b1;
            for (int i = first; i < n && shadow_key[i][31:8] == target; i++) begin
              if (shadow_cnt[i] > a.count) begin
                a.count = shadow_cnt[i];
                a.ch = shadow_key[i][7:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // stimulus building

  function automatic plan_step_t random_request();
    plan_step_t s;
    s = '0;
    s.kind = STEP_REQ;
    s.mode = MODE_SPARE;
    s.index = IdxW'($urandom);
    s.key = $urandom;
    s.count = CountW'($urandom);
    s.ctx = CtxW'($urandom);
    return s;
  endfunction

  task automatic plan_append(input plan_step_t s);
    request_plan = {request_plan, s};
  endtask

  task automatic plan_write(input logic [IdxW-1:0] idx, input logic [KeyW-1:0] key,
                            input logic [CountW-1:0] cnt);
    plan_step_t s;
    s = random_request();
    s.mode = MODE_WRITE;
    s.index = idx;
    s.key = key;
    s.count = cnt;
    plan_key[idx] = key;
    plan_append(s);
  endtask

  task automatic plan_lookup(input logic [KeyW-1:0] key);
    plan_step_t s;
    s = random_request();
    s.mode = MODE_LOOKUP;
    s.key = key;
    plan_append(s);
  endtask

  task automatic plan_predict(input logic [CtxW-1:0] ctx);
    plan_step_t s;
    s = random_request();
    s.mode = MODE_PREDICT;
    s.ctx = ctx;
    plan_append(s);
  endtask

  task automatic plan_config(input logic idx, input logic [CfgW-1:0] val);
    plan_step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.cfg_idx = idx;
    s.cfg_val = val;
    plan_append(s);
  endtask

  task automatic plan_phase(input int idle, input int stall);
    plan_step_t s;
    s = '0;
    s.kind = STEP_PHASE;
    s.idle_pct = 7'(idle);
    s.stall_pct = 7'(stall);
    plan_append(s);
  endtask

  // one random request against a table whose first n entries are live
  task automatic plan_query(input int n);
    int              pick, at;
    logic [KeyW-1:0] k;
    logic [CtxW-1:0] ctx;
    pick = $urandom_range(99);
    at = (n > 0) ? $urandom_range(n - 1) : 0;
    k = plan_key[at];
    if (pick < 35 && n > 0) begin
      // zero bytes in the context stand for spaces
      ctx = k[31:8];
      for (int b = 0; b < 3; b++) begin
        if (ctx[8*b +: 8] == SPACE_CHAR && $urandom_range(1)) ctx[8*b +: 8] = '0;
      end
      plan_predict(ctx);
    end else if (pick < 45) begin
      plan_predict(CtxW'($urandom));
    end else if (pick < 75 && n > 0) begin
      plan_lookup(k);
    end else if (pick < 85) begin
      plan_lookup($urandom);
    end else if (pick < 92 && n < TABLE_DEPTH) begin
      plan_write(IdxW'($urandom_range(TABLE_DEPTH - 1, n)), $urandom, CountW'($urandom));
    end else if (pick < 95 && n > 0) begin
      // overwrite inside the live range, the table may end up unsorted
      plan_write(IdxW'(at), $urandom, CountW'($urandom));
    end else begin
      plan_append(random_request());
    end
  endtask

  // driver: one plan step per cycle at most, payload held while stalled
  always @(posedge clk) begin : driver
    plan_step_t nxt;
    answer_t    ans;
    logic       v;
    logic       we;
    if (rst) begin
      req_valid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      v = req_valid;
      we = 1'b0;
      if (req_valid && !req_stall) begin
        ans = table_answer(mode, entry_index, gram_key, gram_count, context_bytes);
        pending_answers = {pending_answers, ans};
        v = 1'b0;
      end
      if (!v && request_plan.size() > 0) begin
        nxt = request_plan[0];
        case (nxt.kind)
          STEP_PHASE: begin
            send_idle_pct = nxt.idle_pct;
            rsp_stall_pct = nxt.stall_pct;
            void'(request_plan.pop_front());
          end
          STEP_CFG: begin
            // registers change only with nothing in flight
            if (!req_valid && pending_answers.size() == 0) begin
              we = 1'b1;
              cfg_index <= nxt.cfg_idx;
              cfg_data <= nxt.cfg_val;
              if (nxt.cfg_idx == CFG_ENTRIES) shadow_entries = nxt.cfg_val;
              else shadow_order = nxt.cfg_val[2:0];
              void'(request_plan.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              v = 1'b1;
              mode <= nxt.mode;
              entry_index <= nxt.index;
              gram_key <= nxt.key;
              gram_count <= nxt.count;
              context_bytes <= nxt.ctx;
              void'(request_plan.pop_front());
            end
          end
        endcase
      end
      req_valid <= v;
      cfg_we <= we;
    end
  end

  // monitor: compare each accepted result with the oldest predicted answer
  always @(posedge clk) begin : monitor
    answer_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result hit %0d count %h char %h", $time, hit,
                   found_count, next_char);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (hit !== want.hit) begin
            $display("%0t: hit expected %0d got %0d", $time, want.hit, hit);
            errors++;
          end
          if (found_count !== want.count) begin
            $display("%0t: found_count expected %h got %h", $time, want.count, found_count);
            errors++;
          end
          if (next_char !== want.ch) begin
            $display("%0t: next_char expected %h got %h", $time, want.ch, next_char);
            errors++;
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ngram_table_predict_tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [KeyW-1:0] keys[$];
    logic [KeyW-1:0] k;
    logic [CharW-1:0] alphabet [4];
    logic [2:0]      ord;
    plan_step_t      s;
    int              n, pos, h, mid;

    alphabet[0] = SPACE_CHAR;
    alphabet[1] = 8'h61;
    alphabet[2] = 8'h62;
    alphabet[3] = 8'h65;

    // directed: empty table, spare mode, a small hand-built table
    plan_phase(0, 0);
    plan_config(CFG_ENTRIES, '0);
    plan_config(CFG_ORDER, 13'd4);
    plan_lookup(32'h0000_0000);
    plan_predict(24'h746865);
    s = random_request();
    s.index = '1;
    s.key = '1;
    s.count = '1;
    s.ctx = '1;
    plan_append(s);
    plan_write(12'd0, 32'h0000_0000, 16'hFFFF);
    plan_write(12'd1, 32'h2020_2041, 16'd7);
    plan_write(12'd2, 32'h2020_2042, 16'h8000);
    plan_write(12'd3, 32'h6162_6341, 16'd0);
    plan_write(12'd4, 32'h6162_6342, 16'd0);
    plan_write(12'd5, 32'h7468_6520, 16'd5);
    plan_write(12'd6, 32'h7468_6561, 16'd9);
    plan_write(12'd7, 32'h7468_656E, 16'd9);
    plan_write(12'd8, 32'h7468_6579, 16'd3);
    plan_write(12'd9, 32'hFFFF_FFFF, 16'hFFFF);
    plan_write(12'hFFF, 32'hFFFF_FFFF, 16'hFFFF);
    plan_config(CFG_ENTRIES, 13'd10);
    plan_config(CFG_ORDER, 13'd3);
    plan_lookup(32'h7468_656E);
    plan_lookup(32'h0000_0000);
    plan_lookup(32'hFFFF_FFFF);
    plan_lookup(32'h7468_6500);
    plan_predict(24'h746865);   // tie on the best count keeps the first
    plan_predict(24'h000000);   // all blanks map to spaces
    plan_predict(24'h002000);
    plan_predict(24'h616263);   // run with only zero counts
    plan_predict(24'hFFFFFF);
    plan_predict(24'h123456);
    plan_config(CFG_ORDER, 13'd1);
    plan_predict(24'h746865);
    plan_config(CFG_ORDER, 13'd2);
    plan_predict(24'h746865);

    // random phases, each with a freshly loaded small sorted table
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: plan_phase(0, 0);
        1: plan_phase(75, 0);
        2: plan_phase(0, 75);
        default: plan_phase(29, 29);
      endcase
      case (ph)
        0: begin n = 0; ord = 3'd4; end
        1: begin n = 1; ord = 3'd2; end
        2: begin n = 2; ord = 3'd1; end
        3: begin n = 40; ord = 3'd7; end
        default: begin n = $urandom_range(32, 3); ord = 3'($urandom_range(7)); end
      endcase
      keys.delete();
      repeat (n) begin
        k = {alphabet[$urandom_range(3)], alphabet[$urandom_range(3)],
             alphabet[$urandom_range(3)], 8'($urandom)};
        pos = 0;
        while (pos < keys.size() && keys[pos] < k) pos++;
        keys.insert(pos, k);
      end
      foreach (keys[i]) begin
        plan_write(IdxW'(i), keys[i],
                   $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom));
      end
      plan_config(CFG_ENTRIES, CfgW'(n));
      plan_config(CFG_ORDER, {10'($urandom), ord});
      repeat (PHASE_QUERIES) plan_query(n);
    end

    // full-size and saturated entry counts: only the left spine of the search
    // is written, and every query below stays on that spine
    plan_phase(29, 29);
    h = TABLE_DEPTH - 1;
    while (h >= 0) begin
      mid = h / 2;
      plan_write(IdxW'(mid), 32'h6161_6178 + 32'(mid << 8), 16'($urandom_range(500, 1)));
      h = mid - 1;
    end
    for (int pass = 0; pass < 2; pass++) begin
      plan_config(CFG_ENTRIES, (pass == 0) ? 13'd4096 : 13'h1FFF);
      plan_config(CFG_ORDER, (pass == 0) ? 13'd4 : 13'h1FFF);
      h = TABLE_DEPTH - 1;
      while (h >= 0) begin
        mid = h / 2;
        plan_lookup(32'h6161_6178 + 32'(mid << 8));
        h = mid - 1;
      end
      plan_lookup(32'h0000_0001);
      plan_predict(24'h616161);
      plan_predict(24'h000000);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (request_plan.size() != 0 || req_valid || pending_answers.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("ngram_table_predict_tb: clean");
    end else begin
      $display("ngram_table_predict_tb: errors");
    end
    $finish;
  end

endmodule
